[rtl/dcmd_pkg.sv]
// dcmd_pkg: shared types, type-range constants and type classification
// for the data-capture message deframer; no dependencies
`default_nettype none

package dcmd_pkg;

    // message type ranges
    localparam logic [7:0] TYPE_IDLE   = 8'h00;
    localparam logic [7:0] EVT_ANY_A   = 8'h04;
    localparam logic [7:0] EVT_ANY_B   = 8'h07;
    localparam logic [7:0] EVT_WAIT_LO = 8'h20;
    localparam logic [7:0] EVT_ONCE_LO = 8'h2B;
    localparam logic [7:0] EVT_ONCE_HI = 8'h2F;
    localparam logic [7:0] EVT_WAIT_HI = 8'h5F;
    localparam logic [7:0] FRAME_LO    = 8'h60;
    localparam logic [7:0] SPACE_LO    = 8'h63;
    localparam logic [7:0] FRAME_HI    = 8'h66;

    // substitute for a zero payload byte
    localparam logic [7:0] SPACE_CHAR  = 8'h20;

    // how an open message type behaves
    typedef enum logic [2:0] {
        CLS_IDLE,
        CLS_ONCE,
        CLS_WAIT,
        CLS_ANY,
        CLS_FRAME,
        CLS_HOLD
    } class_t;

    // result kind codes
    typedef enum logic {
        KIND_EVENT   = 1'b0,
        KIND_PAYLOAD = 1'b1
    } kind_t;

    // deframer state
    typedef struct packed {
        logic [7:0] cur_type;
        logic [7:0] frame_len;
        logic [8:0] byte_count;
    } state_t;

    // one result request
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] msg_type;
        logic [7:0] payload;
        logic [7:0] position;
        logic       last;
    } result_t;

    // map a type byte to its behaviour class
    function automatic class_t classify(input logic [7:0] t);
        class_t c;
        if (t == TYPE_IDLE)
            c = CLS_IDLE;
        else if (t >= EVT_ONCE_LO && t <= EVT_ONCE_HI)
            c = CLS_ONCE;
        else if (t >= EVT_WAIT_LO && t <= EVT_WAIT_HI)
            c = CLS_WAIT;
        else if (t == EVT_ANY_A || t == EVT_ANY_B)
            c = CLS_ANY;
        else if (t >= FRAME_LO && t <= FRAME_HI)
            c = CLS_FRAME;
        else
            c = CLS_HOLD;
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/data_capture_message_deframer.sv]
// data_capture_message_deframer: top level, state and result registers
// depends on dcmd_pkg and dcmd_decode
//
// Usage:
//   Input channel: rx_byte with in_valid / in_stall. A byte is taken at a
//   clock edge where in_valid is high and in_stall is low.
//   Output channel: kind, msg_type, payload, position, last with out_valid /
//   out_stall. A result is taken where out_valid is high and out_stall low.
//   Each byte gives at most one result: an event when a message type is
//   recognised, or one request per payload byte of a framed message.
//   A result appears on the outputs in the cycle after its byte is
//   taken. Throughput: one byte per cycle unless a held result stalls,
//   set by the single decode stage between the state and result registers.
//   When the receiver stalls, the result register holds and in_stall is
//   raised only while a held result waits; a byte that gives no result
//   still needs the result register free.
//   Reset: the block goes idle, no length is pending and no result is held.
`default_nettype none

module data_capture_message_deframer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            kind,
    output logic [7:0]      msg_type,
    output logic [7:0]      payload,
    output logic [7:0]      position,
    output logic            last
);

    dcmd_pkg::state_t  state_reg;
    dcmd_pkg::state_t  state_next;
    dcmd_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              kind_reg;
    logic [7:0]        msg_type_reg;
    logic [7:0]        payload_reg;
    logic [7:0]        position_reg;
    logic              last_reg;
    logic              in_take;

    // back-pressure only while a held result is not being taken
    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    dcmd_decode u_decode (
        .state      (state_reg),
        .rx_byte    (rx_byte),
        .state_next (state_next),
        .result     (result_next)
    );

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg     <= state_next;
                out_valid_reg <= result_next.valid;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg     <= result_next.kind;
            msg_type_reg <= result_next.msg_type;
            payload_reg  <= result_next.payload;
            position_reg <= result_next.position;
            last_reg     <= result_next.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign msg_type  = msg_type_reg;
    assign payload   = payload_reg;
    assign position  = position_reg;
    assign last      = last_reg;

    // events always carry last with zero payload and position
    a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == dcmd_pkg::KIND_EVENT) |->
            (last && payload == 8'h00 && position == 8'h00))
        else $error("event result with bad fields");

    // a pending length only exists inside a framed message
    a_len_framed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.frame_len != 8'h00) |->
            (state_reg.cur_type >= dcmd_pkg::FRAME_LO &&
             state_reg.cur_type <= dcmd_pkg::FRAME_HI))
        else $error("frame length held outside a framed type");

    // payload count never runs past the frame
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.frame_len != 8'h00) |->
            (state_reg.byte_count <= {1'b0, state_reg.frame_len}))
        else $error("payload count beyond frame length");

    // a final payload byte returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && result_next.valid && result_next.kind == dcmd_pkg::KIND_PAYLOAD
         && result_next.last) |=> (state_reg.cur_type == dcmd_pkg::TYPE_IDLE))
        else $error("block not idle after last payload byte");

endmodule

`default_nettype wire

[rtl/dcmd_decode.sv]
// dcmd_decode: per-byte decision logic, next state and result for one byte
// depends on dcmd_pkg
`default_nettype none

module dcmd_decode (
    input  wire dcmd_pkg::state_t  state,
    input  wire logic [7:0]        rx_byte,
    output dcmd_pkg::state_t       state_next,
    output dcmd_pkg::result_t      result
);

    dcmd_pkg::class_t cls;
    logic [8:0]       count_inc;
    logic             fin;
    logic             match;

    assign cls       = dcmd_pkg::classify(state.cur_type);
    assign count_inc = state.byte_count + 9'd1;
    assign fin       = (count_inc == ({1'b0, state.frame_len} + 9'd1));
    assign match     = (rx_byte == state.cur_type);

    // per-class decision
    always_comb
    begin
        state_next      = state;
        result.valid    = 1'b0;
        result.kind     = dcmd_pkg::KIND_EVENT;
        result.msg_type = state.cur_type;
        result.payload  = 8'h00;
        result.position = 8'h00;
        result.last     = 1'b1;
        unique case (cls)
            dcmd_pkg::CLS_IDLE:
            begin
                state_next.cur_type = rx_byte;
            end
            dcmd_pkg::CLS_ONCE:
            begin
                state_next.cur_type = dcmd_pkg::TYPE_IDLE;
                result.valid        = match;
            end
            dcmd_pkg::CLS_WAIT:
            begin
                if (match)
                begin
                    state_next.cur_type = dcmd_pkg::TYPE_IDLE;
                    result.valid        = 1'b1;
                end
            end
            dcmd_pkg::CLS_ANY:
            begin
                state_next.cur_type = dcmd_pkg::TYPE_IDLE;
                result.valid        = 1'b1;
            end
            dcmd_pkg::CLS_FRAME:
            begin
                if (state.frame_len == 8'h00)
                begin
                    // length byte; zero leaves the length still awaited
                    state_next.frame_len  = rx_byte;
                    state_next.byte_count = 9'd0;
                end
                else
                begin
                    state_next.byte_count = count_inc;
                    result.valid          = 1'b1;
                    result.kind           = dcmd_pkg::KIND_PAYLOAD;
                    result.position       = state.byte_count[7:0];
                    result.last           = fin;
                    if (state.cur_type >= dcmd_pkg::SPACE_LO && rx_byte == 8'h00)
                        result.payload = dcmd_pkg::SPACE_CHAR;
                    else
                        result.payload = rx_byte;
                    if (fin)
                    begin
                        state_next.cur_type  = dcmd_pkg::TYPE_IDLE;
                        state_next.frame_len = 8'h00;
                    end
                end
            end
            dcmd_pkg::CLS_HOLD:
            begin
                // meaningless type: stuck until reset
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/sv/tb_data_capture_message_deframer.sv]
// tb_data_capture_message_deframer: self-checking testbench for the message deframer,
// a directed table followed by random message traffic checked against a local predictor
// depends on dcmd_pkg and data_capture_message_deframer

module tb_data_capture_message_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;

    // one result request as seen on the output channel
    typedef struct packed {
        logic       kind;
        logic [7:0] msg_type;
        logic [7:0] payload;
        logic [7:0] position;
        logic       last;
    } frag_t;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_RESULT
    } chk_t;

    typedef struct packed {
        logic [7:0] rx;
        chk_t       mode;
        frag_t      res;
    } row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       kind;
    logic [7:0] msg_type;
    logic [7:0] payload;
    logic [7:0] position;
    logic       last;

    // predictor state
    logic [7:0] open_type  = 8'h00;
    logic [7:0] frame_len  = 8'h00;
    logic [8:0] taken      = 9'd0;

    frag_t awaited_frags[$];
    row_t  directed_rows[$];
    int    bytes_sent     = 0;
    int    frames_sent    = 0;
    int    mismatch_count = 0;
    int    quiet_cycles   = 0;
    int    send_gap_pct   = 6;
    int    recv_stall_pct = 60;

    data_capture_message_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .msg_type  (msg_type),
        .payload   (payload),
        .position  (position),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic frag_t event_of(input logic [7:0] t);
        frag_t r;
        r = '0;
        r.kind = dcmd_pkg::KIND_EVENT;
        r.msg_type = t;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic frag_t payload_of(input logic [7:0] t, input logic [7:0] d,
                                         input logic [7:0] p, input logic l);
        frag_t r;
        r = '0;
        r.kind = dcmd_pkg::KIND_PAYLOAD;
        r.msg_type = t;
        r.payload = d;
        r.position = p;
        r.last = l;
        return r;
    endfunction

    // deframe one byte: update the predicted state and say what result it gives
    task automatic deframe_byte(input logic [7:0] b, output bit emits, output frag_t r);
        logic [7:0] t;
        logic [7:0] data;
        t = open_type;
        emits = 1'b0;
        r = '0;
        if (t == dcmd_pkg::TYPE_IDLE)
        begin
            open_type = b;
        end
        else if (t >= dcmd_pkg::EVT_ONCE_LO && t <= dcmd_pkg::EVT_ONCE_HI)
        begin
            open_type = dcmd_pkg::TYPE_IDLE;
            if (b == t)
            begin
                emits = 1'b1;
                r = event_of(t);
            end
        end
        else if (t >= dcmd_pkg::EVT_WAIT_LO && t <= dcmd_pkg::EVT_WAIT_HI)
        begin
            if (b == t)
            begin
                open_type = dcmd_pkg::TYPE_IDLE;
                emits = 1'b1;
                r = event_of(t);
            end
        end
        else if (t == dcmd_pkg::EVT_ANY_A || t == dcmd_pkg::EVT_ANY_B)
        begin
            open_type = dcmd_pkg::TYPE_IDLE;
            emits = 1'b1;
            r = event_of(t);
        end
        else if (t >= dcmd_pkg::FRAME_LO && t <= dcmd_pkg::FRAME_HI)
        begin
            if (frame_len == 8'h00)
            begin
                // a zero length leaves the length still awaited
                taken = 9'd0;
                frame_len = b;
            end
            else
            begin
                data = (t >= dcmd_pkg::SPACE_LO && b == 8'h00) ? dcmd_pkg::SPACE_CHAR : b;
                emits = 1'b1;
                r = payload_of(t, data, taken[7:0], 1'b0);
                taken = taken + 9'd1;
                if (taken == {1'b0, frame_len} + 9'd1)
                begin
                    r.last = 1'b1;
                    open_type = dcmd_pkg::TYPE_IDLE;
                    frame_len = 8'h00;
                end
            end
        end
        // any other type holds the block with no result
    endtask

    // offer one byte and wait for it to be taken, then record what it should give
    task automatic send_byte(input logic [7:0] b, input chk_t mode, input frag_t typed);
        bit    took;
        bit    emits;
        frag_t guess;
        if (bytes_sent < 200)
        begin
            send_gap_pct = 6;
            recv_stall_pct = 60;
        end
        else if (bytes_sent < 400)
        begin
            send_gap_pct = 60;
            recv_stall_pct = 6;
        end
        else
        begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = (in_stall === 1'b0);
            if (took)
            begin
                deframe_byte(b, emits, guess);
                if (mode == CHK_RESULT)
                    awaited_frags.push_back(typed);
                else if (mode == CHK_PREDICT && emits)
                    awaited_frags.push_back(guess);
            end
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic add_row(input logic [7:0] b, input chk_t mode, input frag_t res);
        row_t row;
        row.rx = b;
        row.mode = mode;
        row.res = res;
        directed_rows.push_back(row);
    endtask

    function automatic logic [7:0] payload_byte();
        return ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom_range(255));
    endfunction

    // one random message, mostly well formed, some broken or just idle filler
    task automatic send_random_message();
        int         pick;
        int         len;
        int         junk;
        logic [7:0] t;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            send_byte(dcmd_pkg::TYPE_IDLE, CHK_PREDICT, '0);
        end
        else if (pick < 15)
        begin
            t = $urandom_range(1) ? dcmd_pkg::EVT_ANY_A : dcmd_pkg::EVT_ANY_B;
            send_byte(t, CHK_PREDICT, '0);
            send_byte(8'($urandom_range(255)), CHK_PREDICT, '0);
        end
        else if (pick < 35)
        begin
            t = 8'($urandom_range(dcmd_pkg::EVT_ONCE_LO, dcmd_pkg::EVT_ONCE_HI));
            send_byte(t, CHK_PREDICT, '0);
            b = ($urandom_range(99) < 75) ? t : 8'($urandom_range(255));
            send_byte(b, CHK_PREDICT, '0);
        end
        else if (pick < 55)
        begin
            do
                t = 8'($urandom_range(dcmd_pkg::EVT_WAIT_LO, dcmd_pkg::EVT_WAIT_HI));
            while (t >= dcmd_pkg::EVT_ONCE_LO && t <= dcmd_pkg::EVT_ONCE_HI);
            send_byte(t, CHK_PREDICT, '0);
            junk = $urandom_range(3);
            repeat (junk)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == t);
                send_byte(b, CHK_PREDICT, '0);
            end
            send_byte(t, CHK_PREDICT, '0);
        end
        else
        begin
            t = 8'($urandom_range(dcmd_pkg::FRAME_LO, dcmd_pkg::FRAME_HI));
            if (frames_sent == 3)
                len = 255;
            else if ($urandom_range(99) < 85)
                len = $urandom_range(1, 7);
            else
                len = $urandom_range(8, 40);
            frames_sent++;
            send_byte(t, CHK_PREDICT, '0);
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 2))
                    send_byte(8'h00, CHK_PREDICT, '0);
            end
            send_byte(8'(len), CHK_PREDICT, '0);
            repeat (len + 1)
                send_byte(payload_byte(), CHK_PREDICT, '0);
        end
    endtask

    // output monitor and idle-cycle count
    initial
    begin : watch_results
        bit    hit;
        bit    moved;
        frag_t got;
        frag_t want;
        forever
        begin
            @(negedge clk);
            hit = (out_valid === 1'b1) && (out_stall === 1'b0);
            moved = hit || ((in_valid === 1'b1) && (in_stall === 1'b0));
            got = {kind, msg_type, payload, position, last};
            @(posedge clk);
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (hit)
            begin
                if (awaited_frags.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: kind=%0d type=%02h data=%02h pos=%0d last=%0d",
                                 got.kind, got.msg_type, got.payload, got.position, got.last);
                end
                else
                begin
                    want = awaited_frags.pop_front();
                    if (got.kind !== want.kind || got.msg_type !== want.msg_type ||
                        got.payload !== want.payload || got.position !== want.position ||
                        got.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected kind=%0d type=%02h data=%02h pos=%0d ",
                                      "last=%0d, got kind=%0d type=%02h data=%02h pos=%0d last=%0d"},
                                     want.kind, want.msg_type, want.payload, want.position,
                                     want.last, got.kind, got.msg_type, got.payload,
                                     got.position, got.last);
                    end
                end
            end
        end
    end

    // watchdog on a stuck handshake
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        row_t       row;
        logic [7:0] t;
        // directed table: events of every class, broken sequences, frames at the extremes
        add_row(8'h00, CHK_NONE, '0);
        add_row(dcmd_pkg::EVT_ANY_A, CHK_NONE, '0);
        add_row(8'hFF, CHK_RESULT, event_of(dcmd_pkg::EVT_ANY_A));
        add_row(dcmd_pkg::EVT_ANY_B, CHK_NONE, '0);
        add_row(8'h00, CHK_RESULT, event_of(dcmd_pkg::EVT_ANY_B));
        add_row(dcmd_pkg::EVT_ONCE_LO, CHK_NONE, '0);
        add_row(dcmd_pkg::EVT_ONCE_LO, CHK_RESULT, event_of(dcmd_pkg::EVT_ONCE_LO));
        add_row(dcmd_pkg::EVT_ONCE_HI, CHK_NONE, '0);
        add_row(8'h2E, CHK_NONE, '0);
        add_row(dcmd_pkg::EVT_WAIT_LO, CHK_NONE, '0);
        add_row(8'h55, CHK_NONE, '0);
        add_row(dcmd_pkg::EVT_WAIT_LO, CHK_RESULT, event_of(dcmd_pkg::EVT_WAIT_LO));
        add_row(dcmd_pkg::EVT_WAIT_HI, CHK_NONE, '0);
        add_row(dcmd_pkg::EVT_WAIT_HI, CHK_RESULT, event_of(dcmd_pkg::EVT_WAIT_HI));
        add_row(dcmd_pkg::FRAME_LO, CHK_NONE, '0);
        add_row(8'h00, CHK_NONE, '0);
        add_row(8'h01, CHK_NONE, '0);
        add_row(8'h00, CHK_RESULT, payload_of(dcmd_pkg::FRAME_LO, 8'h00, 8'd0, 1'b0));
        add_row(8'hFF, CHK_RESULT, payload_of(dcmd_pkg::FRAME_LO, 8'hFF, 8'd1, 1'b1));
        add_row(dcmd_pkg::FRAME_HI, CHK_NONE, '0);
        add_row(8'h01, CHK_NONE, '0);
        add_row(8'h00, CHK_RESULT,
                payload_of(dcmd_pkg::FRAME_HI, dcmd_pkg::SPACE_CHAR, 8'd0, 1'b0));
        add_row(8'h80, CHK_PREDICT, '0);
        add_row(8'h62, CHK_NONE, '0);
        add_row(8'h01, CHK_NONE, '0);
        add_row(8'h00, CHK_RESULT, payload_of(8'h62, 8'h00, 8'd0, 1'b0));
        add_row(8'h7F, CHK_PREDICT, '0);

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_byte(row.rx, row.mode, row.res);
        end

        // random message traffic
        while (bytes_sent < 600)
            send_random_message();

        // an unknown type holds the block for the rest of the run
        do
            t = 8'($urandom_range(1, 255));
        while (t == dcmd_pkg::EVT_ANY_A || t == dcmd_pkg::EVT_ANY_B ||
               (t >= dcmd_pkg::EVT_WAIT_LO && t <= dcmd_pkg::FRAME_HI));
        send_byte(t, CHK_PREDICT, '0);
        send_byte(t, CHK_PREDICT, '0);
        send_byte(8'h00, CHK_PREDICT, '0);
        repeat (8)
            send_byte(8'($urandom_range(255)), CHK_PREDICT, '0);
        in_valid <= 1'b0;

        // drain
        while (awaited_frags.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
